// ----- rtl/core/cnlb_pkg.sv -----
// ----------------------------------------------------------------------------
// cnlb_pkg: card number Luhn / brand check package
// Shared widths, brand codes, controller state and command/status types.
// ----------------------------------------------------------------------------
package cnlb_pkg;

    localparam int unsigned NUM_W   = 54;               // binary card number width
    localparam int unsigned DIGITS  = 17;               // decimal digits of a 54-bit value
    localparam int unsigned BCD_W   = 4 * DIGITS;
    localparam int unsigned BITCNT_W = $clog2(NUM_W);   // counts convert and walk steps
    localparam int unsigned LEN_W   = 5;

    localparam logic [1:0] BRAND_INVALID    = 2'd0;
    localparam logic [1:0] BRAND_AMEX       = 2'd1;
    localparam logic [1:0] BRAND_MASTERCARD = 2'd2;
    localparam logic [1:0] BRAND_VISA       = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_WALK,
        ST_FINISH
    } cnlb_state_t;

    typedef struct packed {
        logic load;      // capture a new card number
        logic conv;      // one double-dabble step
        logic walk;      // one digit of the Luhn walk
        logic publish;   // write the result register
    } cnlb_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic walk_last;
    } cnlb_stat_t;

    // doubled digit with digit sum folding (value minus nine above nine)
    function automatic logic [3:0] luhn_double(input logic [3:0] d);
        logic [4:0] dd;
        begin
            dd = {d, 1'b0};
            if (dd > 5'd9)
            begin
                dd = dd - 5'd9;
            end
            luhn_double = dd[3:0];
        end
    endfunction

endpackage

// ----- rtl/core/cnlb_if.sv -----
// ----------------------------------------------------------------------------
// cnlb_if: transfer channels of the card check
// Input channel carries the card number, result channel the verdict.
// ----------------------------------------------------------------------------
interface cnlb_card_if;
    logic        valid;
    logic        ready;
    logic [53:0] card_number;

    modport source (output valid, output card_number, input ready);
    modport sink   (input valid, input card_number, output ready);
endinterface

interface cnlb_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] brand;
    logic       luhn_ok;
    logic [4:0] digit_count;

    modport source (output valid, output brand, output luhn_ok, output digit_count,
                    input ready);
    modport sink   (input valid, input brand, input luhn_ok, input digit_count,
                    output ready);
endinterface

// ----- rtl/core/cnlb_ctrl.sv -----
// ----------------------------------------------------------------------------
// cnlb_ctrl: card check controller
// Sequences load, binary-to-decimal conversion, digit walk and result write.
// ----------------------------------------------------------------------------
module cnlb_ctrl
    import cnlb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  cnlb_stat_t stat,
    output cnlb_cmd_t  cmd
);

    cnlb_state_t state_reg;
    cnlb_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    // result register may be written when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (stat.conv_last)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CONVERT:
            begin
                cmd.conv = 1'b1;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.publish = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // result valid flag: set on write, cleared on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/cnlb_dp.sv -----
// ----------------------------------------------------------------------------
// cnlb_dp: card check datapath
// Bit-serial double dabble into BCD, then a digit-serial Luhn and prefix walk.
// ----------------------------------------------------------------------------
module cnlb_dp
    import cnlb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cnlb_cmd_t         cmd,
    output cnlb_stat_t        stat,
    input  logic [NUM_W-1:0]  card_number,
    output logic [1:0]        brand,
    output logic              luhn_ok,
    output logic [LEN_W-1:0]  digit_count
);

    logic [NUM_W-1:0]    bin_reg,  bin_next;
    logic [BCD_W-1:0]    bcd_reg,  bcd_next;
    logic [BITCNT_W-1:0] cnt_reg,  cnt_next;
    logic [3:0]          acc_reg,  acc_next;    // Luhn sum mod 10
    logic [LEN_W-1:0]    len_reg,  len_next;
    logic [3:0]          lead_reg, lead_next;
    logic [3:0]          sec_reg,  sec_next;
    logic [3:0]          prev_reg, prev_next;
    logic [1:0]          brand_reg;
    logic                ok_reg;
    logic [LEN_W-1:0]    count_reg;

    logic [BCD_W-1:0]    bcd_adj;
    logic [3:0]          dig;
    logic [3:0]          contrib;
    logic [4:0]          acc_sum;
    logic [1:0]          brand_new;

    assign stat.conv_last = (cnt_reg == BITCNT_W'(NUM_W - 1));
    assign stat.walk_last = (cnt_reg == BITCNT_W'(DIGITS - 1));

    // add three to every decimal digit of five or more before the shift
    always_comb
    begin
        for (int k = 0; k < DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
    end

    // current digit contribution, digits at odd zero-based positions from the right are doubled
    assign dig     = bcd_reg[3:0];
    assign contrib = cnt_reg[0] ? luhn_double(dig) : dig;
    assign acc_sum = {1'b0, acc_reg} + {1'b0, contrib};

    // step logic for conversion and walk
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        len_next  = len_reg;
        lead_next = lead_reg;
        sec_next  = sec_reg;
        prev_next = prev_reg;
        if (cmd.load)
        begin
            bin_next  = card_number;
            bcd_next  = '0;
            cnt_next  = '0;
            acc_next  = '0;
            len_next  = '0;
            lead_next = '0;
            sec_next  = '0;
            prev_next = '0;
        end
        else if (cmd.conv)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[NUM_W-1]};
            bin_next = {bin_reg[NUM_W-2:0], 1'b0};
            cnt_next = stat.conv_last ? '0 : cnt_reg + 1'b1;
        end
        else if (cmd.walk)
        begin
            bcd_next  = {4'd0, bcd_reg[BCD_W-1:4]};
            cnt_next  = cnt_reg + 1'b1;
            acc_next  = (acc_sum >= 5'd10) ? 4'(acc_sum - 5'd10) : acc_sum[3:0];
            prev_next = dig;
            if (dig != 4'd0)
            begin
                len_next  = cnt_reg[LEN_W-1:0] + 1'b1;
                lead_next = dig;
                sec_next  = prev_reg;
            end
        end
    end

    // brand by length and leading digits, only on a Luhn pass
    always_comb
    begin
        brand_new = BRAND_INVALID;
        if (acc_reg == 4'd0)
        begin
            if (len_reg == 5'd15 && lead_reg == 4'd3 && sec_reg inside {4'd4, 4'd7})
            begin
                brand_new = BRAND_AMEX;
            end
            else if (len_reg == 5'd16 && lead_reg == 4'd5 && sec_reg inside {[4'd1:4'd5]})
            begin
                brand_new = BRAND_MASTERCARD;
            end
            else if ((len_reg == 5'd13 || len_reg == 5'd16) && lead_reg == 4'd4)
            begin
                brand_new = BRAND_VISA;
            end
        end
    end

    // step counter is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        acc_reg  <= acc_next;
        len_reg  <= len_next;
        lead_reg <= lead_next;
        sec_reg  <= sec_next;
        prev_reg <= prev_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            brand_reg <= brand_new;
            ok_reg    <= (acc_reg == 4'd0);
            count_reg <= len_reg;
        end
    end

    assign brand       = brand_reg;
    assign luhn_ok     = ok_reg;
    assign digit_count = count_reg;

endmodule

// ----- rtl/core/card_number_luhn_brand_check_top.sv -----
// ----------------------------------------------------------------------------
// card_number_luhn_brand_check_top: card number Luhn and brand check
//
//   channel  role  transfer carries
//   card     sink  card_number[53:0]
//   result   src   brand[1:0], luhn_ok, digit_count[4:0]
//
// One card number at a time: accept, 54 double-dabble steps, 17 digit
// steps and one result write. A new card is taken the cycle after the
// result is written; the result register holds it while the sink stalls,
// and a full register stalls the finish step. Reset clears the controller
// and the result valid flag.
// ----------------------------------------------------------------------------
module card_number_luhn_brand_check_top
    import cnlb_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    cnlb_card_if.sink      card,
    cnlb_result_if.source  result
);

    cnlb_cmd_t  cmd;
    cnlb_stat_t stat;

    // sequencing
    cnlb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (card.valid),
        .in_ready  (card.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // conversion, digit walk and result register
    cnlb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .card_number (card.card_number),
        .brand       (result.brand),
        .luhn_ok     (result.luhn_ok),
        .digit_count (result.digit_count)
    );

endmodule
